>>> hdl/cbp_pkg.sv
// Shared types and constants for the chained buffer pool.
`timescale 1ns / 1ps
`default_nettype none
package cbp_pkg;

    // Pool geometry
    localparam int SLOT_COUNT  = 64;
    localparam int SLOT_BYTES  = 32;
    localparam int DESCRIPTORS = 8;

    localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
    localparam int PTR_W       = 7;
    localparam int POS_W       = $clog2(SLOT_BYTES);
    localparam int FILL_W      = POS_W + 1;
    localparam int BADDR_W     = SLOT_IDX_W + POS_W;
    localparam int REF_W       = 8;
    localparam int LEN_W       = 12;
    localparam int CNT_W       = 7;
    localparam int DESC_W      = $clog2(DESCRIPTORS);

    localparam logic [PTR_W-1:0] NIL_SLOT = '1;
    localparam logic [REF_W-1:0] MAX_REF  = '1;
    localparam logic [LEN_W-1:0] MAX_LEN  = '1;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [PTR_W-1:0]      slot_ptr_t;

    typedef enum logic [2:0] {
        KIND_OPEN    = 3'd0,
        KIND_APPEND  = 3'd1,
        KIND_READ    = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_REWIND  = 3'd4,
        KIND_SHARE   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_WRITE = 2'd2,
        ST_NO_DATA  = 2'd3
    } status_t;

    // Per-slot bookkeeping
    typedef struct packed {
        logic [REF_W-1:0]  refcount;
        logic [FILL_W-1:0] fill;
        slot_ptr_t         link;
    } slot_meta_t;

    typedef struct packed {
        logic       en;
        slot_idx_t  addr;
        slot_meta_t data;
    } meta_wr_t;

endpackage
`default_nettype wire

>>> hdl/cbp_req_if.sv
// Request channel interface of the chained buffer pool.
`timescale 1ns / 1ps
`default_nettype none
interface cbp_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [2:0] buffer_id;
    logic [7:0] data_in;
    logic [2:0] target_id;

    modport source (output valid, output kind, output buffer_id, output data_in,
                    output target_id, input ready);
    modport sink   (input valid, input kind, input buffer_id, input data_in,
                    input target_id, output ready);
endinterface
`default_nettype wire

>>> hdl/cbp_rsp_if.sv
// Result channel interface of the chained buffer pool.
`timescale 1ns / 1ps
`default_nettype none
interface cbp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  data_out;
    logic [6:0]  free_count;
    logic [11:0] buffer_length;

    modport source (output valid, output status, output data_out, output free_count,
                    output buffer_length, input ready);
    modport sink   (input valid, input status, input data_out, input free_count,
                    input buffer_length, output ready);
endinterface
`default_nettype wire

>>> hdl/cbp_byte_mem.sv
// Slot byte storage: single-port synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
module cbp_byte_mem
    import cbp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic               rd_en,
    input  wire logic [BADDR_W-1:0] addr,
    input  wire logic [7:0]         wr_data,
    output logic [7:0]              rd_data
);

    logic [7:0] mem [SLOT_COUNT*SLOT_BYTES];
    logic [7:0] rd_data_reg;

    // Write or registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hdl/cbp_slot_mem.sv
// Slot metadata RAM with valid bits, free map, free count and allocator.
`timescale 1ns / 1ps
`default_nettype none
module cbp_slot_mem
    import cbp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      rd_en,
    input  wire slot_idx_t rd_addr,
    input  wire meta_wr_t  wr,
    output slot_meta_t     rd_data,
    output logic           free_any,
    output slot_idx_t      free_idx,
    output logic [CNT_W-1:0] free_count
);

    slot_meta_t              mem [SLOT_COUNT];
    slot_meta_t              rd_q_reg;
    logic                    rd_vld_reg;
    logic [SLOT_COUNT-1:0]   valid_reg;
    logic [SLOT_COUNT-1:0]   free_map_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    old_free;
    logic                    new_free;

    // Metadata array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign old_free = free_map_reg[wr.addr];
    assign new_free = (wr.data.refcount == '0);

    // Valid bits, free map and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            free_map_reg <= '1;
            count_reg    <= CNT_W'(SLOT_COUNT);
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (wr.en)
            begin
                valid_reg[wr.addr]    <= 1'b1;
                free_map_reg[wr.addr] <= new_free;
                if (old_free && !new_free)
                begin
                    count_reg <= count_reg - 1'b1;
                end
                else if (!old_free && new_free)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // Unwritten entries read as the reset value
    always_comb
    begin
        if (rd_vld_reg)
        begin
            rd_data = rd_q_reg;
        end
        else
        begin
            rd_data = '{refcount: '0, fill: '0, link: NIL_SLOT};
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (free_map_reg[i])
            begin
                free_idx = SLOT_IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    assign free_count = count_reg;

endmodule
`default_nettype wire

>>> hdl/chained_buffer_pool.sv
// Top level: descriptor table and operation sequencer of the chained buffer pool.
// Open, rewind and unused kinds go from S_START straight to S_DONE; read passes through S_RD_DATA;
// append passes through S_APP_META, and also S_APP_LINK when a new slot is chained; release and share
// walk the chain through S_WALK_RD and S_WALK_WR (one metadata read and write per slot).
// One item at a time; the next item is taken the cycle after the result enters the output register.
// Reset (async, active low): all slots free, descriptors nil, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module chained_buffer_pool
    import cbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cbp_req_if.sink   req,
    cbp_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_APP_META, S_APP_LINK, S_RD_DATA, S_WALK_RD, S_WALK_WR, S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]        kind_reg, kind_next;
    logic [DESC_W-1:0] id_reg, id_next;
    logic [7:0]        byte_reg, byte_next;
    logic [DESC_W-1:0] tgt_reg, tgt_next;
    slot_ptr_t         walk_reg, walk_next;
    logic [CNT_W-1:0]  walk_n_reg, walk_n_next;
    slot_ptr_t         ns_reg, ns_next;
    status_t           status_reg, status_next;
    logic [7:0]        data_reg, data_next;

    logic              rsp_valid_reg, rsp_valid_next;
    status_t           rsp_status_reg, rsp_status_next;
    logic [7:0]        rsp_data_reg, rsp_data_next;
    logic [CNT_W-1:0]  rsp_free_reg, rsp_free_next;
    logic [LEN_W-1:0]  rsp_len_reg, rsp_len_next;

    slot_ptr_t         desc_head_reg  [DESCRIPTORS];
    slot_ptr_t         desc_head_next [DESCRIPTORS];
    slot_ptr_t         desc_wr_reg    [DESCRIPTORS];
    slot_ptr_t         desc_wr_next   [DESCRIPTORS];
    slot_ptr_t         desc_rd_reg    [DESCRIPTORS];
    slot_ptr_t         desc_rd_next   [DESCRIPTORS];
    logic [POS_W-1:0]  desc_pos_reg   [DESCRIPTORS];
    logic [POS_W-1:0]  desc_pos_next  [DESCRIPTORS];
    logic [LEN_W-1:0]  desc_len_reg   [DESCRIPTORS];
    logic [LEN_W-1:0]  desc_len_next  [DESCRIPTORS];

    slot_ptr_t         cur_head, cur_wr, cur_rd;
    logic [POS_W-1:0]  cur_pos;
    logic [LEN_W-1:0]  cur_len, len_inc;

    logic              meta_rd_en;
    slot_idx_t         meta_rd_addr;
    meta_wr_t          meta_wr;
    slot_meta_t        meta_q;
    logic              free_any;
    slot_idx_t         free_idx;
    logic [CNT_W-1:0]  free_count;

    logic              byte_wr_en, byte_rd_en;
    logic [BADDR_W-1:0] byte_addr;
    logic [7:0]        byte_q;

    cbp_slot_mem u_slot_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (meta_rd_en),
        .rd_addr    (meta_rd_addr),
        .wr         (meta_wr),
        .rd_data    (meta_q),
        .free_any   (free_any),
        .free_idx   (free_idx),
        .free_count (free_count)
    );

    cbp_byte_mem u_byte_mem (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .rd_en   (byte_rd_en),
        .addr    (byte_addr),
        .wr_data (byte_reg),
        .rd_data (byte_q)
    );

    // Addressed descriptor
    assign cur_head = desc_head_reg[id_reg];
    assign cur_wr   = desc_wr_reg[id_reg];
    assign cur_rd   = desc_rd_reg[id_reg];
    assign cur_pos  = desc_pos_reg[id_reg];
    assign cur_len  = desc_len_reg[id_reg];
    assign len_inc  = (cur_len < MAX_LEN) ? cur_len + 1'b1 : cur_len;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.data_out      = rsp_data_reg;
    assign rsp.free_count    = rsp_free_reg;
    assign rsp.buffer_length = rsp_len_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        byte_next       = byte_reg;
        tgt_next        = tgt_reg;
        walk_next       = walk_reg;
        walk_n_next     = walk_n_reg;
        ns_next         = ns_reg;
        status_next     = status_reg;
        data_next       = data_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_free_next   = rsp_free_reg;
        rsp_len_next    = rsp_len_reg;
        desc_head_next  = desc_head_reg;
        desc_wr_next    = desc_wr_reg;
        desc_rd_next    = desc_rd_reg;
        desc_pos_next   = desc_pos_reg;
        desc_len_next   = desc_len_reg;
        meta_rd_en      = 1'b0;
        meta_rd_addr    = '0;
        meta_wr         = '0;
        byte_wr_en      = 1'b0;
        byte_rd_en      = 1'b0;
        byte_addr       = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next   = req.kind;
                    id_next     = req.buffer_id;
                    byte_next   = req.data_in;
                    tgt_next    = req.target_id;
                    status_next = ST_OK;
                    data_next   = '0;
                    state_next  = S_START;
                end
            end

            S_START:
            begin
                state_next = S_DONE;
                case (kind_reg)
                    KIND_OPEN:
                    begin
                        desc_pos_next[id_reg] = '0;
                        desc_len_next[id_reg] = '0;
                        if (free_any)
                        begin
                            meta_wr.en   = 1'b1;
                            meta_wr.addr = free_idx;
                            meta_wr.data = '{refcount: REF_W'(1), fill: '0, link: NIL_SLOT};
                            desc_head_next[id_reg] = PTR_W'(free_idx);
                            desc_wr_next[id_reg]   = PTR_W'(free_idx);
                            desc_rd_next[id_reg]   = PTR_W'(free_idx);
                        end
                        else
                        begin
                            desc_head_next[id_reg] = NIL_SLOT;
                            desc_wr_next[id_reg]   = NIL_SLOT;
                            desc_rd_next[id_reg]   = NIL_SLOT;
                            status_next            = ST_FULL;
                        end
                    end
                    KIND_APPEND:
                    begin
                        if (cur_wr >= PTR_W'(SLOT_COUNT))
                        begin
                            status_next = ST_NO_WRITE;
                        end
                        else
                        begin
                            meta_rd_en   = 1'b1;
                            meta_rd_addr = cur_wr[SLOT_IDX_W-1:0];
                            state_next   = S_APP_META;
                        end
                    end
                    KIND_READ:
                    begin
                        if (cur_rd >= PTR_W'(SLOT_COUNT))
                        begin
                            status_next = ST_NO_DATA;
                        end
                        else
                        begin
                            meta_rd_en   = 1'b1;
                            meta_rd_addr = cur_rd[SLOT_IDX_W-1:0];
                            byte_rd_en   = 1'b1;
                            byte_addr    = {cur_rd[SLOT_IDX_W-1:0], cur_pos};
                            state_next   = S_RD_DATA;
                        end
                    end
                    KIND_RELEASE, KIND_SHARE:
                    begin
                        walk_next   = cur_head;
                        walk_n_next = '0;
                        state_next  = S_WALK_RD;
                    end
                    KIND_REWIND:
                    begin
                        desc_rd_next[id_reg]  = cur_head;
                        desc_pos_next[id_reg] = '0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_APP_META:
            begin
                state_next = S_DONE;
                if ((meta_q.fill >= FILL_W'(SLOT_BYTES)) || (cur_head == NIL_SLOT))
                begin
                    if (!free_any)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // link the current slot, first byte goes to the new one
                        meta_wr.en        = 1'b1;
                        meta_wr.addr      = cur_wr[SLOT_IDX_W-1:0];
                        meta_wr.data      = meta_q;
                        meta_wr.data.link = PTR_W'(free_idx);
                        byte_wr_en        = 1'b1;
                        byte_addr         = {free_idx, POS_W'(0)};
                        ns_next           = PTR_W'(free_idx);
                        state_next        = S_APP_LINK;
                    end
                end
                else
                begin
                    meta_wr.en        = 1'b1;
                    meta_wr.addr      = cur_wr[SLOT_IDX_W-1:0];
                    meta_wr.data      = meta_q;
                    meta_wr.data.fill = meta_q.fill + 1'b1;
                    byte_wr_en        = 1'b1;
                    byte_addr         = {cur_wr[SLOT_IDX_W-1:0], meta_q.fill[POS_W-1:0]};
                    desc_len_next[id_reg] = len_inc;
                end
            end

            S_APP_LINK:
            begin
                // a slot chained to itself keeps its own link
                meta_wr.en   = 1'b1;
                meta_wr.addr = ns_reg[SLOT_IDX_W-1:0];
                meta_wr.data = '{refcount: REF_W'(1), fill: FILL_W'(1),
                                 link: (ns_reg == cur_wr) ? ns_reg : NIL_SLOT};
                desc_wr_next[id_reg] = ns_reg;
                if (cur_head == NIL_SLOT)
                begin
                    desc_head_next[id_reg] = ns_reg;
                    desc_rd_next[id_reg]   = ns_reg;
                end
                desc_len_next[id_reg] = len_inc;
                state_next            = S_DONE;
            end

            S_RD_DATA:
            begin
                state_next = S_DONE;
                if (FILL_W'(cur_pos) >= meta_q.fill)
                begin
                    status_next = ST_NO_DATA;
                end
                else
                begin
                    data_next = byte_q;
                    if ((FILL_W'(cur_pos) + 1'b1) >= meta_q.fill)
                    begin
                        desc_rd_next[id_reg]  = meta_q.link;
                        desc_pos_next[id_reg] = '0;
                    end
                    else
                    begin
                        desc_pos_next[id_reg] = cur_pos + 1'b1;
                    end
                end
            end

            S_WALK_RD:
            begin
                if ((walk_reg >= PTR_W'(SLOT_COUNT)) || (walk_n_reg == CNT_W'(SLOT_COUNT)))
                begin
                    state_next = S_DONE;
                    if (kind_reg == KIND_RELEASE)
                    begin
                        desc_head_next[id_reg] = NIL_SLOT;
                        desc_wr_next[id_reg]   = NIL_SLOT;
                        desc_rd_next[id_reg]   = NIL_SLOT;
                        desc_pos_next[id_reg]  = '0;
                        desc_len_next[id_reg]  = '0;
                    end
                    else
                    begin
                        desc_head_next[tgt_reg] = cur_head;
                        desc_wr_next[tgt_reg]   = cur_wr;
                        desc_rd_next[tgt_reg]   = cur_head;
                        desc_pos_next[tgt_reg]  = '0;
                        desc_len_next[tgt_reg]  = cur_len;
                    end
                end
                else
                begin
                    meta_rd_en   = 1'b1;
                    meta_rd_addr = walk_reg[SLOT_IDX_W-1:0];
                    state_next   = S_WALK_WR;
                end
            end

            S_WALK_WR:
            begin
                // write back the count; the next read is issued in the following cycle, from S_WALK_RD
                meta_wr.en   = 1'b1;
                meta_wr.addr = walk_reg[SLOT_IDX_W-1:0];
                meta_wr.data = meta_q;
                if (kind_reg == KIND_RELEASE)
                begin
                    if (meta_q.refcount != '0)
                    begin
                        meta_wr.data.refcount = meta_q.refcount - 1'b1;
                    end
                end
                else if (meta_q.refcount != MAX_REF)
                begin
                    meta_wr.data.refcount = meta_q.refcount + 1'b1;
                end
                walk_next   = meta_q.link;
                walk_n_next = walk_n_reg + 1'b1;
                state_next  = S_WALK_RD;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_data_next   = data_reg;
                    rsp_free_next   = free_count;
                    rsp_len_next    = cur_len;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, descriptors and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int d = 0; d < DESCRIPTORS; d++)
            begin
                desc_head_reg[d] <= NIL_SLOT;
                desc_wr_reg[d]   <= NIL_SLOT;
                desc_rd_reg[d]   <= NIL_SLOT;
                desc_pos_reg[d]  <= '0;
                desc_len_reg[d]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            desc_head_reg <= desc_head_next;
            desc_wr_reg   <= desc_wr_next;
            desc_rd_reg   <= desc_rd_next;
            desc_pos_reg  <= desc_pos_next;
            desc_len_reg  <= desc_len_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        byte_reg       <= byte_next;
        tgt_reg        <= tgt_next;
        walk_reg       <= walk_next;
        walk_n_reg     <= walk_n_next;
        ns_reg         <= ns_next;
        status_reg     <= status_next;
        data_reg       <= data_next;
        rsp_status_reg <= rsp_status_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_free_reg   <= rsp_free_next;
        rsp_len_reg    <= rsp_len_next;
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_START))
        else $error("transfer in did not start an operation");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!rsp_valid_reg || rsp.ready)) |=> rsp_valid_reg)
        else $error("finished operation left no result");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_WR) |-> (walk_n_reg < CNT_W'(SLOT_COUNT)))
        else $error("chain walk exceeded pool size");

    a_link_after_meta: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APP_LINK) |-> ($past(state_reg) == S_APP_META))
        else $error("slot chaining without metadata read");
`endif

endmodule
`default_nettype wire

>>> tb/chained_buffer_pool_tb.sv
// Testbench for the chained buffer pool: directed and random operations checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module chained_buffer_pool_tb;
    import cbp_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data_out;
        logic [6:0]  free_count;
        logic [11:0] buffer_length;
    } pool_result_t;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count;

    cbp_req_if req ();
    cbp_rsp_if rsp ();

    chained_buffer_pool DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Predicted pool state
    logic [7:0]  pm_ref   [SLOT_COUNT];
    logic [5:0]  pm_fill  [SLOT_COUNT];
    logic [7:0]  pm_link  [SLOT_COUNT];
    logic [7:0]  pm_bytes [SLOT_COUNT*SLOT_BYTES];
    int          pm_free;
    logic [7:0]  pm_head  [DESCRIPTORS];
    logic [7:0]  pm_wslot [DESCRIPTORS];
    logic [7:0]  pm_rslot [DESCRIPTORS];
    logic [4:0]  pm_rpos  [DESCRIPTORS];
    logic [11:0] pm_len   [DESCRIPTORS];
    localparam logic [7:0] NONE = 8'hFF;

    pool_result_t pending_results[$];

    // Clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [7:0] grab_free_slot();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (pm_ref[i] == 0)
            begin
                pm_ref[i]  = 1;
                pm_fill[i] = 0;
                pm_link[i] = NONE;
                if (pm_free > 0)
                    pm_free--;
                return 8'(i);
            end
        end
        return NONE;
    endfunction

    function automatic void walk_chain(logic [7:0] s, bit up);
        for (int n = 0; s != NONE && s < SLOT_COUNT && n < SLOT_COUNT; n++)
        begin
            if (up)
            begin
                if (pm_ref[s] == 0 && pm_free > 0)
                    pm_free--;
                if (pm_ref[s] < 8'hFF)
                    pm_ref[s]++;
            end
            else if (pm_ref[s] > 0)
            begin
                pm_ref[s]--;
                if (pm_ref[s] == 0)
                    pm_free++;
            end
            s = pm_link[s];
        end
    endfunction

    function automatic pool_result_t predict_pool_op(logic [2:0] kind, logic [2:0] id,
                                                     logic [7:0] din, logic [2:0] tgt);
        pool_result_t r;
        logic [7:0] s;
        logic [7:0] ns;
        int pos;
        r = '0;
        r.status = ST_OK;
        case (kind)
            KIND_OPEN:
            begin
                s = grab_free_slot();
                pm_head[id] = s;
                pm_wslot[id] = s;
                pm_rslot[id] = s;
                pm_rpos[id] = 0;
                pm_len[id] = 0;
                if (s == NONE)
                    r.status = ST_FULL;
            end
            KIND_APPEND:
            begin
                s = pm_wslot[id];
                if (s == NONE || s >= SLOT_COUNT)
                    r.status = ST_NO_WRITE;
                else
                begin
                    pos = pm_fill[s];
                    ns = 0;
                    if (pos >= SLOT_BYTES || pm_head[id] == NONE)
                    begin
                        ns = grab_free_slot();
                        if (ns == NONE)
                            r.status = ST_FULL;
                        else
                        begin
                            pm_link[s] = ns;
                            pm_wslot[id] = ns;
                            if (pm_head[id] == NONE)
                            begin
                                pm_head[id] = ns;
                                pm_rslot[id] = ns;
                            end
                            s = ns;
                            pos = 0;
                        end
                    end
                    if (r.status == ST_OK)
                    begin
                        pm_bytes[s*SLOT_BYTES+pos] = din;
                        pm_fill[s] = 6'(pos + 1);
                        if (pm_len[id] < 12'hFFF)
                            pm_len[id]++;
                    end
                end
            end
            KIND_READ:
            begin
                s = pm_rslot[id];
                pos = pm_rpos[id];
                if (s == NONE || s >= SLOT_COUNT || pos >= pm_fill[s])
                    r.status = ST_NO_DATA;
                else
                begin
                    r.data_out = pm_bytes[s*SLOT_BYTES+pos];
                    if (pos + 1 >= pm_fill[s])
                    begin
                        pm_rslot[id] = pm_link[s];
                        pm_rpos[id] = 0;
                    end
                    else
                        pm_rpos[id] = 5'(pos + 1);
                end
            end
            KIND_RELEASE:
            begin
                walk_chain(pm_head[id], 1'b0);
                pm_head[id] = NONE;
                pm_wslot[id] = NONE;
                pm_rslot[id] = NONE;
                pm_rpos[id] = 0;
                pm_len[id] = 0;
            end
            KIND_REWIND:
            begin
                pm_rslot[id] = pm_head[id];
                pm_rpos[id] = 0;
            end
            KIND_SHARE:
            begin
                walk_chain(pm_head[id], 1'b1);
                pm_head[tgt] = pm_head[id];
                pm_len[tgt] = pm_len[id];
                pm_rslot[tgt] = pm_head[id];
                pm_rpos[tgt] = 0;
                pm_wslot[tgt] = pm_wslot[id];
            end
            default:
            begin
            end
        endcase
        r.free_count = 7'(pm_free);
        r.buffer_length = pm_len[id];
        return r;
    endfunction

    // Send one operation and record its expected result; valid stays up until
    // the next call idles or the run drops it
    task automatic send_op(logic [2:0] kind, logic [2:0] id, logic [7:0] din,
                           logic [2:0] tgt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.kind      <= kind;
        req.buffer_id <= id;
        req.data_in   <= din;
        req.target_id <= tgt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.push_back(predict_pool_op(kind, id, din, tgt));
    endtask

    // Receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.data_out !== want.data_out)
                begin
                    $error("data_out expected %0d actual %0d", want.data_out, rsp.data_out);
                    fail_count++;
                end
                if (rsp.free_count !== want.free_count)
                begin
                    $error("free_count expected %0d actual %0d", want.free_count,
                           rsp.free_count);
                    fail_count++;
                end
                if (rsp.buffer_length !== want.buffer_length)
                begin
                    $error("buffer_length expected %0d actual %0d", want.buffer_length,
                           rsp.buffer_length);
                    fail_count++;
                end
            end
        end
    end

    // Directed: every kind, extremes, full pool, read past end, unused kinds
    task automatic test_directed();
        send_op(KIND_APPEND, 3'd0, 8'h00, 3'd0);
        send_op(KIND_READ, 3'd0, 8'h00, 3'd0);
        send_op(KIND_OPEN, 3'd7, 8'h00, 3'd0);
        send_op(KIND_APPEND, 3'd7, 8'hFF, 3'd7);
        send_op(KIND_APPEND, 3'd7, 8'h00, 3'd0);
        send_op(KIND_READ, 3'd7, 8'h00, 3'd0);
        send_op(KIND_READ, 3'd7, 8'h00, 3'd0);
        send_op(KIND_READ, 3'd7, 8'h00, 3'd0);
        send_op(KIND_REWIND, 3'd7, 8'h00, 3'd0);
        send_op(KIND_SHARE, 3'd7, 8'h00, 3'd0);
        send_op(KIND_SHARE, 3'd7, 8'h00, 3'd7);
        send_op(KIND_RELEASE, 3'd0, 8'h00, 3'd0);
        send_op(3'd6, 3'd7, 8'hAA, 3'd1);
        send_op(3'd7, 3'd0, 8'h55, 3'd2);
        send_op(KIND_RELEASE, 3'd7, 8'h00, 3'd0);
        send_op(KIND_RELEASE, 3'd7, 8'h00, 3'd0);
        // append to the released descriptor 0, then exhaust the pool with opens and hit the full status on open
        for (int i = 0; i < 33; i++)
            send_op(KIND_APPEND, 3'd0, 8'(i * 37), 3'd0);
        send_op(KIND_OPEN, 3'd1, 8'h00, 3'd0);
        for (int i = 0; i < SLOT_COUNT; i++)
            send_op(KIND_OPEN, 3'(2 + i % 6), 8'h00, 3'd0);
        send_op(KIND_OPEN, 3'd0, 8'h00, 3'd0);
        for (int i = 0; i < 8; i++)
            send_op(KIND_RELEASE, 3'(i), 8'h00, 3'd0);
    endtask

    // Random: mostly open/append/read sequences with occasional release, rewind, share and unused kinds
    task automatic test_random(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                send_op(KIND_OPEN, 3'($urandom), 8'($urandom), 3'($urandom));
            else if (pick < 50)
                send_op(KIND_APPEND, 3'($urandom), 8'($urandom), 3'($urandom));
            else if (pick < 80)
                send_op(KIND_READ, 3'($urandom), 8'($urandom), 3'($urandom));
            else if (pick < 86)
                send_op(KIND_RELEASE, 3'($urandom), 8'($urandom), 3'($urandom));
            else if (pick < 92)
                send_op(KIND_REWIND, 3'($urandom), 8'($urandom), 3'($urandom));
            else if (pick < 98)
                send_op(KIND_SHARE, 3'($urandom), 8'($urandom), 3'($urandom));
            else
                send_op(3'($urandom_range(7, 6)), 3'($urandom), 8'($urandom),
                        3'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        fail_count = 0;
        send_idle_pct = 27;
        recv_idle_pct = 65;
        req.valid = 1'b0;
        req.kind = '0;
        req.buffer_id = '0;
        req.data_in = '0;
        req.target_id = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            pm_ref[i] = 0;
            pm_fill[i] = 0;
            pm_link[i] = NONE;
        end
        foreach (pm_bytes[i])
            pm_bytes[i] = 0;
        pm_free = SLOT_COUNT;
        for (int i = 0; i < DESCRIPTORS; i++)
        begin
            pm_head[i] = NONE;
            pm_wslot[i] = NONE;
            pm_rslot[i] = NONE;
            pm_rpos[i] = 0;
            pm_len[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(550);
        send_idle_pct = 65;
        recv_idle_pct = 27;
        test_random(650);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(650);
        req.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

>>> chained_buffer_pool.f
hdl/cbp_pkg.sv
hdl/cbp_req_if.sv
hdl/cbp_rsp_if.sv
hdl/cbp_byte_mem.sv
hdl/cbp_slot_mem.sv
hdl/chained_buffer_pool.sv
tb/chained_buffer_pool_tb.sv
